>>> sv/tmtd_pkg.sv
// ----------------------------------------------------------------------------
// tmtd_pkg: shared types and constants
// Phase codes, register indexes, reset values and the control word that
// travels with each request through the root and divide cell rows.
// ----------------------------------------------------------------------------
`default_nettype none

package tmtd_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [1:0] PH_ACCEL  = 2'd0;
	localparam logic [1:0] PH_CRUISE = 2'd1;
	localparam logic [1:0] PH_DECEL  = 2'd2;

	localparam int         NUM_REGS   = 6;
	localparam logic [2:0] REG_LEN    = 3'd0;
	localparam logic [2:0] REG_VSTART = 3'd1;
	localparam logic [2:0] REG_VEND   = 3'd2;
	localparam logic [2:0] REG_ACCEL  = 3'd3;
	localparam logic [2:0] REG_VMAX   = 3'd4;
	localparam logic [2:0] REG_STEP   = 3'd5;

	localparam logic [31:0] RST_LEN    = 32'd0;
	localparam logic [31:0] RST_VSTART = 32'd0;
	localparam logic [31:0] RST_VEND   = 32'd0;
	localparam logic [31:0] RST_ACCEL  = 32'd65536;
	localparam logic [31:0] RST_VMAX   = 32'd655360;
	localparam logic [31:0] RST_STEP   = 32'd65536;

	typedef struct packed {
		logic       user;
		logic [1:0] phase;
		logic       sq;
		logic       sh;
		logic       neg;
		logic       numz;
	} ctl_t;

endpackage

`default_nettype wire

>>> sv/tmtd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tmtd_sqrt_cell: one root digit
// Settles one bit of the integer square root of the operand (if sq is set,
// else unchanged) and hands the partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtd_sqrt_cell #(
	parameter int PW   = 66,
	parameter int RADW = 66,
	parameter int SW   = 96,
	parameter int B    = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire tmtd_pkg::ctl_t  ctl_in,
	input  wire logic [PW-1:0]   op_in,
	input  wire logic [RADW-1:0] res_in,
	input  wire logic [SW-1:0]   side_in,
	output logic                 v_out,
	output tmtd_pkg::ctl_t       ctl_out,
	output logic [PW-1:0]        op_out,
	output logic [RADW-1:0]      res_out,
	output logic [SW-1:0]        side_out
);

	logic [RADW-1:0] one;
	logic [RADW-1:0] sum;
	logic            ge;
	logic            v_s1;
	tmtd_pkg::ctl_t  ctl_s1;
	logic [PW-1:0]   op_s1;
	logic [RADW-1:0] res_s1;
	logic [SW-1:0]   side_s1;

	assign one = RADW'(1) << (2 * B);
	assign sum = res_in + one;
	assign ge  = op_in >= PW'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_in;
			side_s1 <= side_in;
			if (ctl_in.sq && ge) begin
				op_s1  <= op_in - PW'(sum);
				res_s1 <= (res_in >> 1) + one;
			end else if (ctl_in.sq) begin
				op_s1  <= op_in;
				res_s1 <= res_in >> 1;
			end else begin
				op_s1  <= op_in;
				res_s1 <= res_in;
			end
		end
	end

	assign v_out    = v_s1;
	assign ctl_out  = ctl_s1;
	assign op_out   = op_s1;
	assign res_out  = res_s1;
	assign side_out = side_s1;

endmodule

`default_nettype wire

>>> sv/tmtd_div_cell.sv
// ----------------------------------------------------------------------------
// tmtd_div_cell: one quotient digit
// Restoring division step: shifts in one numerator bit, trial-subtracts the
// divisor and shifts the quotient bit into the vacated position.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtd_div_cell #(
	parameter int W  = 32,
	parameter int ND = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           v_in,
	input  wire tmtd_pkg::ctl_t ctl_in,
	input  wire logic [ND-1:0]  x_in,
	input  wire logic [W-1:0]   r_in,
	input  wire logic [W-1:0]   d_in,
	input  wire logic [W-1:0]   add_in,
	output logic                v_out,
	output tmtd_pkg::ctl_t      ctl_out,
	output logic [ND-1:0]       x_out,
	output logic [W-1:0]        r_out,
	output logic [W-1:0]        d_out,
	output logic [W-1:0]        add_out
);

	logic [W:0]     rr;
	logic [W:0]     rn;
	logic           ge;
	logic           v_s1;
	tmtd_pkg::ctl_t ctl_s1;
	logic [ND-1:0]  x_s1;
	logic [W-1:0]   r_s1;
	logic [W-1:0]   d_s1;
	logic [W-1:0]   add_s1;

	assign rr = {r_in, x_in[ND-1]};
	assign ge = rr >= {1'b0, d_in};
	assign rn = ge ? rr - {1'b0, d_in} : rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			x_s1   <= {x_in[ND-2:0], ge};
			r_s1   <= rn[W-1:0];
			d_s1   <= d_in;
			add_s1 <= add_in;
		end
	end

	assign v_out   = v_s1;
	assign ctl_out = ctl_s1;
	assign x_out   = x_s1;
	assign r_out   = r_s1;
	assign d_out   = d_s1;
	assign add_out = add_s1;

endmodule

`default_nettype wire

>>> sv/tmtd_front.sv
// ----------------------------------------------------------------------------
// tmtd_front: request front end
// Classifies each distance into its segment, forms the acceleration product
// and builds the root and divide job for the cell rows.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtd_front #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int PW = 66
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           acc,
	input  wire logic [W-1:0]   distance,
	input  wire logic [W-1:0]   s1,
	input  wire logic [W-1:0]   bnd,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   vs,
	input  wire logic [2*W-1:0] vs2,
	input  wire logic [W-1:0]   vm,
	input  wire logic [2*W-1:0] vm2,
	input  wire logic [W-1:0]   ts1,
	input  wire logic [W-1:0]   ts2,
	output logic                job_v,
	output tmtd_pkg::ctl_t      job_ctl,
	output logic [PW-1:0]       job_op,
	output logic [W-1:0]        job_off,
	output logic [W-1:0]        job_div,
	output logic [W-1:0]        job_add
);

	logic [1:0]     ph;
	logic [W-1:0]   m;
	logic           v_s1;
	logic [W-1:0]   l_s1;
	logic [1:0]     ph_s1;
	logic [W-1:0]   m_s1;
	logic           v_s2;
	logic [W-1:0]   l_s2;
	logic [1:0]     ph_s2;
	logic [2*W-1:0] prod_s2;
	logic [2*W:0]   tw;

	assign ph = (distance < s1) ? tmtd_pkg::PH_ACCEL :
		(distance < bnd) ? tmtd_pkg::PH_CRUISE : tmtd_pkg::PH_DECEL;
	assign m  = (ph == tmtd_pkg::PH_ACCEL) ? distance : distance - bnd;
	assign tw = {prod_s2, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1    <= distance;
			ph_s1   <= ph;
			m_s1    <= m;
			l_s2    <= l_s1;
			ph_s2   <= ph_s1;
			prod_s2 <= a * m_s1;
		end
	end

	always_comb begin
		job_v         = v_s2;
		job_ctl       = '0;
		job_ctl.user  = 1'b1;
		job_ctl.phase = ph_s2;
		job_op        = '0;
		job_off       = '0;
		job_div       = a;
		job_add       = '0;
		case (ph_s2)
			tmtd_pkg::PH_ACCEL: begin
				job_op      = PW'({2'b00, vs2} + {1'b0, prod_s2, 1'b0});
				job_ctl.sq  = 1'b1;
				job_ctl.sh  = 1'b1;
				job_off     = vs;
			end
			tmtd_pkg::PH_CRUISE: begin
				job_op  = PW'(l_s2 - s1) << F;
				job_div = vm;
				job_add = ts1;
			end
			default: begin
				job_op      = (tw < {1'b0, vm2}) ? PW'({1'b0, vm2} - tw) : '0;
				job_ctl.sq  = 1'b1;
				job_ctl.sh  = 1'b1;
				job_ctl.neg = 1'b1;
				job_off     = vm;
				job_add     = ts2;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/tmtd_setup.sv
// ----------------------------------------------------------------------------
// tmtd_setup: profile sequencer
// Derives peak speed, segment lengths and segment times after reset and
// after each register write, issuing its root and divide jobs to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module tmtd_setup #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int PW = 66
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         restart,
	input  wire logic [W-1:0] len,
	input  wire logic [W-1:0] vs,
	input  wire logic [W-1:0] ve,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] vmax,
	input  wire logic [W-1:0] step,
	input  wire logic         res_pulse,
	input  wire logic [W-1:0] res_t,
	output logic              busy,
	output logic              job_v,
	output tmtd_pkg::ctl_t    job_ctl,
	output logic [PW-1:0]     job_op,
	output logic [W-1:0]      job_off,
	output logic [W-1:0]      job_div,
	output logic [W-1:0]      job_add,
	output logic [2*W-1:0]    vs2,
	output logic [W-1:0]      vm,
	output logic [2*W-1:0]    vm2,
	output logic [W-1:0]      s1,
	output logic [W-1:0]      bnd,
	output logic [W-1:0]      ts1,
	output logic [W-1:0]      ts2
);

	localparam int RADW = 2 * W + 2;

	localparam logic [4:0] ST_START  = 5'd0;
	localparam logic [4:0] ST_MVS    = 5'd1;
	localparam logic [4:0] ST_MVE    = 5'd2;
	localparam logic [4:0] ST_MAL    = 5'd3;
	localparam logic [4:0] ST_HALF   = 5'd4;
	localparam logic [4:0] ST_VM_GO  = 5'd5;
	localparam logic [4:0] ST_VM_W   = 5'd6;
	localparam logic [4:0] ST_MVM    = 5'd7;
	localparam logic [4:0] ST_S1_GO  = 5'd8;
	localparam logic [4:0] ST_S1_W   = 5'd9;
	localparam logic [4:0] ST_S3_GO  = 5'd10;
	localparam logic [4:0] ST_S3_W   = 5'd11;
	localparam logic [4:0] ST_MS1    = 5'd12;
	localparam logic [4:0] ST_TS1_GO = 5'd13;
	localparam logic [4:0] ST_TS1_W  = 5'd14;
	localparam logic [4:0] ST_TS2_GO = 5'd15;
	localparam logic [4:0] ST_TS2_W  = 5'd16;
	localparam logic [4:0] ST_DONE   = 5'd17;

	logic [4:0]      state_q;
	logic            pend_q;
	logic [2*W-1:0]  mul_q;
	logic [2*W-1:0]  vs2_q;
	logic [2*W-1:0]  ve2_q;
	logic [2*W-1:0]  vm2_q;
	logic [RADW-1:0] half_q;
	logic [W-1:0]    vm_q;
	logic [W-1:0]    s1_q;
	logic [W-1:0]    s3_q;
	logic [W-1:0]    s2_q;
	logic [W-1:0]    bnd_q;
	logic [W-1:0]    ts1_q;
	logic [W-1:0]    ts2_q;
	logic [W-1:0]    ma;
	logic [W-1:0]    mb;
	logic            mul_en;
	logic [W-1:0]    r1;
	logic [W-1:0]    r2;
	logic [W-1:0]    s2_n;

	always_comb begin
		mul_en = 1'b1;
		ma     = '0;
		mb     = '0;
		unique case (state_q)
			ST_MVS: begin
				ma = vs;
				mb = vs;
			end
			ST_MVE: begin
				ma = ve;
				mb = ve;
			end
			ST_MAL: begin
				ma = a;
				mb = len;
			end
			ST_MVM: begin
				ma = vm_q;
				mb = vm_q;
			end
			ST_MS1: begin
				ma = a;
				mb = s1_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign r1   = (s1_q > len) ? '0 : len - s1_q;
	assign r2   = (s3_q > r1) ? '0 : r1 - s3_q;
	assign s2_n = (r2 < step) ? '0 : r2;

	always_comb begin
		job_v   = 1'b0;
		job_ctl = '0;
		job_op  = '0;
		job_off = '0;
		job_div = a;
		job_add = '0;
		unique case (state_q)
			ST_VM_GO: begin
				job_v      = 1'b1;
				job_ctl.sq = 1'b1;
				job_op     = PW'(half_q);
				job_div    = W'(1);
			end
			ST_S1_GO: begin
				job_v  = 1'b1;
				job_op = (vm_q > vs) ? PW'((mul_q - vs2_q) >> 1) : '0;
			end
			ST_S3_GO: begin
				job_v  = 1'b1;
				job_op = (vm_q > ve) ? PW'((vm2_q - ve2_q) >> 1) : '0;
			end
			ST_TS1_GO: begin
				job_v      = 1'b1;
				job_ctl.sq = 1'b1;
				job_ctl.sh = 1'b1;
				job_op     = PW'({2'b00, vs2_q} + {1'b0, mul_q, 1'b0});
				job_off    = vs;
			end
			ST_TS2_GO: begin
				job_v   = 1'b1;
				job_op  = PW'(s2_q) << F;
				job_div = vm_q;
				job_add = ts1_q;
			end
			default: job_v = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			pend_q  <= 1'b0;
		end else begin
			if (job_v) begin
				pend_q <= 1'b1;
			end else if (res_pulse) begin
				pend_q <= 1'b0;
			end
			if (restart) begin
				state_q <= ST_START;
			end else begin
				unique case (state_q)
					ST_START:  if (!pend_q) state_q <= ST_MVS;
					ST_MVS:    state_q <= ST_MVE;
					ST_MVE:    state_q <= ST_MAL;
					ST_MAL:    state_q <= ST_HALF;
					ST_HALF:   state_q <= ST_VM_GO;
					ST_VM_GO:  state_q <= ST_VM_W;
					ST_VM_W:   if (res_pulse) state_q <= ST_MVM;
					ST_MVM:    state_q <= ST_S1_GO;
					ST_S1_GO:  state_q <= ST_S1_W;
					ST_S1_W:   if (res_pulse) state_q <= ST_S3_GO;
					ST_S3_GO:  state_q <= ST_S3_W;
					ST_S3_W:   if (res_pulse) state_q <= ST_MS1;
					ST_MS1:    state_q <= ST_TS1_GO;
					ST_TS1_GO: state_q <= ST_TS1_W;
					ST_TS1_W:  if (res_pulse) state_q <= ST_TS2_GO;
					ST_TS2_GO: state_q <= ST_TS2_W;
					ST_TS2_W:  if (res_pulse) state_q <= ST_DONE;
					ST_DONE:   state_q <= ST_DONE;
					default:   state_q <= ST_START;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= ma * mb;
		end
		if (state_q == ST_MVE) begin
			vs2_q <= mul_q;
		end
		if (state_q == ST_MAL) begin
			ve2_q <= mul_q;
		end
		if (state_q == ST_HALF) begin
			half_q <= RADW'(vs2_q >> 1) + RADW'(ve2_q >> 1) + RADW'(vs[0] & ve[0])
				+ RADW'(mul_q);
		end
		if (state_q == ST_VM_W && res_pulse) begin
			vm_q <= (res_t > vmax) ? vmax : res_t;
		end
		if (state_q == ST_S1_GO) begin
			vm2_q <= mul_q;
		end
		if (state_q == ST_S1_W && res_pulse) begin
			s1_q <= (res_t < step) ? '0 : res_t;
		end
		if (state_q == ST_S3_W && res_pulse) begin
			s3_q <= (res_t < step) ? '0 : res_t;
		end
		if (state_q == ST_MS1) begin
			s2_q  <= s2_n;
			bnd_q <= s1_q + s2_n;
		end
		if (state_q == ST_TS1_W && res_pulse) begin
			ts1_q <= res_t;
		end
		if (state_q == ST_TS2_W && res_pulse) begin
			ts2_q <= res_t;
		end
	end

	assign busy = state_q != ST_DONE;
	assign vs2  = vs2_q;
	assign vm   = vm_q;
	assign vm2  = vm2_q;
	assign s1   = s1_q;
	assign bnd  = bnd_q;
	assign ts1  = ts1_q;
	assign ts2  = ts2_q;

endmodule

`default_nettype wire

>>> sv/trapezoid_motion_time_at_distance_top.sv
// ND is the larger of 2*WORD_WIDTH and WORD_WIDTH+FRAC_BITS+1.
// Throughput: one request per cycle while req_ready is high (no result back-pressure,
//   no profile pass), set by the root row of WORD_WIDTH+1 cells and the divide row
//   of ND cells, each cell one stage.
// Reset and every register write start a profile pass of five jobs through the same cells,
//   during which req_ready stays low.
// ----------------------------------------------------------------------------
// trapezoid_motion_time_at_distance_top: trapezoidal profile time lookup
// Returns the arrival time and segment for each queried stroke distance.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_motion_time_at_distance_top #(
	parameter int WORD_WIDTH = tmtd_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = tmtd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [4:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [WORD_WIDTH-1:0] distance,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic [WORD_WIDTH-1:0]      arrival_time,
	output logic [1:0]                 phase
);

	localparam int W    = WORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int RB   = W + 1;
	localparam int RADW = 2 * W + 2;
	localparam int ND   = (2 * W > W + 1 + F) ? 2 * W : W + 1 + F;
	localparam int PW   = (RADW > ND) ? RADW : ND;
	localparam int SW   = 3 * W;

	logic [31:0]    regs_q [0:tmtd_pkg::NUM_REGS-1];
	logic [2:0]     ridx;
	logic           wr;
	logic [W-1:0]   len_w;
	logic [W-1:0]   vs_w;
	logic [W-1:0]   ve_w;
	logic [W-1:0]   a_raw;
	logic [W-1:0]   a_w;
	logic [W-1:0]   vmax_w;
	logic [W-1:0]   step_w;

	logic           en;
	logic           busy;
	logic           acc;
	logic           fr_v;
	tmtd_pkg::ctl_t fr_ctl;
	logic [PW-1:0]  fr_op;
	logic [W-1:0]   fr_off;
	logic [W-1:0]   fr_div;
	logic [W-1:0]   fr_add;
	logic           su_v;
	tmtd_pkg::ctl_t su_ctl;
	logic [PW-1:0]  su_op;
	logic [W-1:0]   su_off;
	logic [W-1:0]   su_div;
	logic [W-1:0]   su_add;
	logic [2*W-1:0] vs2;
	logic [W-1:0]   vm;
	logic [2*W-1:0] vm2;
	logic [W-1:0]   s1;
	logic [W-1:0]   bnd;
	logic [W-1:0]   ts1;
	logic [W-1:0]   ts2;

	logic           sv   [0:RB];
	tmtd_pkg::ctl_t sc   [0:RB];
	logic [PW-1:0]  sop  [0:RB];
	logic [RADW-1:0] sres [0:RB];
	logic [SW-1:0]  sside [0:RB];

	logic           dv   [0:ND];
	tmtd_pkg::ctl_t dc   [0:ND];
	logic [ND-1:0]  dx   [0:ND];
	logic [W-1:0]   dr   [0:ND];
	logic [W-1:0]   dd   [0:ND];
	logic [W-1:0]   da   [0:ND];

	logic [RB-1:0]  root;
	logic [RB-1:0]  off_x;
	logic [RB-1:0]  diff;
	logic [ND-1:0]  num;
	tmtd_pkg::ctl_t jctl;
	logic           qhi;
	logic [W-1:0]   qs;
	logic [W:0]     tsum;
	logic [W-1:0]   tval;

	logic           fin_v_s5;
	tmtd_pkg::ctl_t fin_ctl_s5;
	logic [W-1:0]   fin_t_s5;
	logic           res_pulse;
	logic           res_valid_q;
	logic [W-1:0]   arrival_time_q;
	logic [1:0]     phase_q;

	// configuration port
	assign ridx   = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (ridx < 3'(tmtd_pkg::NUM_REGS)) ? regs_q[ridx] : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[tmtd_pkg::REG_LEN]    <= tmtd_pkg::RST_LEN;
			regs_q[tmtd_pkg::REG_VSTART] <= tmtd_pkg::RST_VSTART;
			regs_q[tmtd_pkg::REG_VEND]   <= tmtd_pkg::RST_VEND;
			regs_q[tmtd_pkg::REG_ACCEL]  <= tmtd_pkg::RST_ACCEL;
			regs_q[tmtd_pkg::REG_VMAX]   <= tmtd_pkg::RST_VMAX;
			regs_q[tmtd_pkg::REG_STEP]   <= tmtd_pkg::RST_STEP;
		end else if (wr && ridx < 3'(tmtd_pkg::NUM_REGS)) begin
			regs_q[ridx] <= pwdata;
		end
	end

	assign len_w  = W'(regs_q[tmtd_pkg::REG_LEN]);
	assign vs_w   = W'(regs_q[tmtd_pkg::REG_VSTART]);
	assign ve_w   = W'(regs_q[tmtd_pkg::REG_VEND]);
	assign a_raw  = W'(regs_q[tmtd_pkg::REG_ACCEL]);
	assign a_w    = (a_raw == '0) ? W'(1) : a_raw;
	assign vmax_w = W'(regs_q[tmtd_pkg::REG_VMAX]);
	assign step_w = W'(regs_q[tmtd_pkg::REG_STEP]);

	// advance unless a user result at the end would overwrite a waiting one
	assign en        = !(fin_v_s5 && fin_ctl_s5.user) || !res_valid_q || res_ready;
	assign req_ready = en && !busy;
	assign acc       = req_valid && req_ready;

	tmtd_setup #(.W(W), .F(F), .PW(PW)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (wr),
		.len       (len_w),
		.vs        (vs_w),
		.ve        (ve_w),
		.a         (a_w),
		.vmax      (vmax_w),
		.step      (step_w),
		.res_pulse (res_pulse),
		.res_t     (fin_t_s5),
		.busy      (busy),
		.job_v     (su_v),
		.job_ctl   (su_ctl),
		.job_op    (su_op),
		.job_off   (su_off),
		.job_div   (su_div),
		.job_add   (su_add),
		.vs2       (vs2),
		.vm        (vm),
		.vm2       (vm2),
		.s1        (s1),
		.bnd       (bnd),
		.ts1       (ts1),
		.ts2       (ts2)
	);

	tmtd_front #(.W(W), .F(F), .PW(PW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.acc      (acc),
		.distance (distance),
		.s1       (s1),
		.bnd      (bnd),
		.a        (a_w),
		.vs       (vs_w),
		.vs2      (vs2),
		.vm       (vm),
		.vm2      (vm2),
		.ts1      (ts1),
		.ts2      (ts2),
		.job_v    (fr_v),
		.job_ctl  (fr_ctl),
		.job_op   (fr_op),
		.job_off  (fr_off),
		.job_div  (fr_div),
		.job_add  (fr_add)
	);

	// chain entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv[0] <= 1'b0;
		end else if (en) begin
			sv[0] <= fr_v || su_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (su_v) begin
				sc[0]    <= su_ctl;
				sop[0]   <= su_op;
				sside[0] <= {su_off, su_div, su_add};
			end else begin
				sc[0]    <= fr_ctl;
				sop[0]   <= fr_op;
				sside[0] <= {fr_off, fr_div, fr_add};
			end
		end
	end

	assign sres[0] = '0;

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		tmtd_sqrt_cell #(.PW(PW), .RADW(RADW), .SW(SW), .B(RB - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (sv[k]),
			.ctl_in   (sc[k]),
			.op_in    (sop[k]),
			.res_in   (sres[k]),
			.side_in  (sside[k]),
			.v_out    (sv[k+1]),
			.ctl_out  (sc[k+1]),
			.op_out   (sop[k+1]),
			.res_out  (sres[k+1]),
			.side_out (sside[k+1])
		);
	end

	// join: form the numerator from the root, or take the operand when no root is taken
	assign root  = sres[RB][RB-1:0];
	assign off_x = RB'(sside[RB][SW-1:2*W]);
	assign diff  = sc[RB].neg ? off_x - root : root - off_x;
	assign num   = sc[RB].sq ? (sc[RB].sh ? ND'(diff) << F : ND'(diff)) : sop[RB][ND-1:0];

	always_comb begin
		jctl      = sc[RB];
		jctl.numz = num == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= sv[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc[0] <= jctl;
			dx[0] <= num;
			dd[0] <= sside[RB][2*W-1:W];
			da[0] <= sside[RB][W-1:0];
		end
	end

	assign dr[0] = '0;

	for (genvar k = 0; k < ND; k++) begin : g_div
		tmtd_div_cell #(.W(W), .ND(ND)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (dv[k]),
			.ctl_in  (dc[k]),
			.x_in    (dx[k]),
			.r_in    (dr[k]),
			.d_in    (dd[k]),
			.add_in  (da[k]),
			.v_out   (dv[k+1]),
			.ctl_out (dc[k+1]),
			.x_out   (dx[k+1]),
			.r_out   (dr[k+1]),
			.d_out   (dd[k+1]),
			.add_out (da[k+1])
		);
	end

	// finish: saturate quotient, add segment base time
	assign qhi  = |dx[ND][ND-1:W];
	assign qs   = dc[ND].numz ? '0 : (qhi ? '1 : dx[ND][W-1:0]);
	assign tsum = {1'b0, da[ND]} + {1'b0, qs};
	assign tval = tsum[W] ? '1 : tsum[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s5 <= 1'b0;
		end else if (en) begin
			fin_v_s5 <= dv[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_ctl_s5 <= dc[ND];
			fin_t_s5   <= tval;
		end
	end

	assign res_pulse = fin_v_s5 && !fin_ctl_s5.user;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en && fin_v_s5 && fin_ctl_s5.user) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && fin_v_s5 && fin_ctl_s5.user) begin
			arrival_time_q <= fin_t_s5;
			phase_q        <= fin_ctl_s5.phase;
		end
	end

	assign res_valid    = res_valid_q;
	assign arrival_time = arrival_time_q;
	assign phase        = phase_q;

`ifndef ASSERT_OFF
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		su_v |-> !fr_v)
		else $error("setup job collides with request");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (phase == tmtd_pkg::PH_ACCEL || phase == tmtd_pkg::PH_CRUISE ||
			phase == tmtd_pkg::PH_DECEL))
		else $error("result carries no segment code");

	a_setup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_pulse |-> busy)
		else $error("setup result returned outside profile pass");

	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !fr_v || $past(busy, 2) == 1'b0)
		else $error("request entered during profile pass");
`endif

endmodule

`default_nettype wire
